// ----- hw/rtl/dla_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// DHCP lease allocator package
// Shared types, constants and codes for the lease allocator block.
// ----------------------------------------------------------------------------
package dla_pkg;

  // Lease table geometry.
  localparam int LeaseSlots = 8;
  localparam int IdxW       = (LeaseSlots > 1) ? $clog2(LeaseSlots) : 1;

  // Message types and fixed constants.
  localparam logic [7:0]  ModeDiscover   = 8'd1;
  localparam logic [7:0]  ModeRequest    = 8'd3;
  localparam logic [15:0] ExpiryLowFill  = 16'hffff;
  localparam logic [9:0]  MsPerSecond    = 10'd1000;

  // Register reset values.
  localparam logic [31:0] ServerIpReset     = 32'hC0A8_0401;
  localparam logic [7:0]  BaseHostReset     = 8'd16;
  localparam logic [22:0] LeaseSecondsReset = 23'(24 * 60 * 60);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SERVER_IP     = 2'd0,
    REG_BASE_HOST     = 2'd1,
    REG_LEASE_SECONDS = 2'd2
  } cfg_reg_e;

  // Reply kinds.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_OFFER = 2'd1,
    KIND_ACK   = 2'd2
  } kind_e;

  // Drop causes.
  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_NO_TYPE   = 3'd1,
    CAUSE_FULL      = 3'd2,
    CAUSE_NO_REQ    = 3'd3,
    CAUSE_FOREIGN   = 3'd4,
    CAUSE_RANGE     = 3'd5,
    CAUSE_HELD      = 3'd6
  } cause_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_WALK_END,
    S_RESULT
  } state_e;

  // Input item.
  typedef struct packed {
    logic [7:0]  mode;
    logic        type_present;
    logic [47:0] client_mac;
    logic        requested_present;
    logic [31:0] requested_ip;
    logic [31:0] now_ms;
  } req_item_t;

  // Result item.
  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [31:0] assigned_ip;
    logic [2:0]  drop_cause;
  } rsp_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   load;
    logic   walk_init;
    logic   walk_step;
    logic   commit;
    logic   post;
    kind_e  kind;
    cause_e cause;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic type_present;
    logic is_discover;
    logic is_request;
    logic req_present;
    logic subnet_ok;
    logic slot_ok;
    logic held;
    logic walk_match;
    logic walk_last;
    logic pick_valid;
  } status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dla_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// DHCP lease allocator channels
// Valid/ready channels for requests, replies and configuration writes.
// ----------------------------------------------------------------------------

// Request channel.
interface dla_req_if;
  logic                 valid;
  logic                 ready;
  dla_pkg::req_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Reply channel.
interface dla_rsp_if;
  logic                 valid;
  logic                 ready;
  dla_pkg::rsp_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface dla_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/dla_top.sv -----
`default_nettype none
// Sequence: an accepted request is decoded in S_DECODE; an acknowledge or a
// drop is then offered in S_RESULT. A discover passes through S_WALK, which
// walks one lease slot per cycle until a match or the last slot, and S_WALK_END.
// Throughput: one item at a time; the next item is accepted in the cycle
// after the reply is taken.
// Reset: rst_ni clears the lease table, the controller and restores registers.
// ----------------------------------------------------------------------------
// DHCP lease allocator top level
// Connects the request, reply and configuration channels to the controller
// and the lease table datapath.
// ----------------------------------------------------------------------------
module dhcp_lease_allocator_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dla_req_if.sink   req_i,
  dla_rsp_if.source rsp_o,
  dla_cfg_if.sink   cfg_i
);
  import dla_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Configuration is always accepted.
  assign cfg_i.ready = 1'b1;

  dla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dla_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .item_i      (req_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .rsp_o       (rsp_o.data)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/dla_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// DHCP lease allocator datapath
// Configuration registers, lease table, slot walk and reply register.
// ----------------------------------------------------------------------------
module dla_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  input  wire dla_pkg::req_item_t  item_i,
  input  wire dla_pkg::cmd_t       cmd_i,
  output dla_pkg::status_t         status_o,
  output dla_pkg::rsp_item_t       rsp_o
);
  import dla_pkg::*;

  // Configuration registers.
  logic [31:0] server_ip_q;
  logic [7:0]  base_host_q;
  logic [22:0] lease_seconds_q;

  // Captured item and lease length in milliseconds.
  req_item_t   item_q;
  logic [31:0] lease_ms_q;
  logic [31:0] lease_ms_full;

  // Lease table.
  logic [47:0] owner_q  [LeaseSlots];
  logic [15:0] expiry_q [LeaseSlots];

  // Walk state.
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] pick_q;
  logic            pick_valid_q;

  // Reply register.
  logic [1:0]  res_kind_q;
  logic [31:0] res_ip_q;
  logic [2:0]  res_cause_q;

  // Derived values.
  logic [7:0]      req_slot8;
  logic [IdxW-1:0] req_slot;
  logic [47:0]     req_owner;
  logic [47:0]     walk_owner;
  logic [31:0]     walk_full;
  logic [31:0]     walk_diff;
  logic            walk_expired;
  logic            walk_match;
  logic [31:0]     lease_end;
  logic [IdxW-1:0] post_slot;
  logic [31:0]     post_ip;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_ip_q     <= ServerIpReset;
      base_host_q     <= BaseHostReset;
      lease_seconds_q <= LeaseSecondsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SERVER_IP:     server_ip_q     <= cfg_data_i;
        REG_BASE_HOST:     base_host_q     <= cfg_data_i[7:0];
        REG_LEASE_SECONDS: lease_seconds_q <= cfg_data_i[22:0];
        default: ;
      endcase
    end
  end

  // Lease length in milliseconds, kept modulo 2^32.
  assign lease_ms_full = 32'(lease_seconds_q) * 32'(MsPerSecond);

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q     <= item_i;
      lease_ms_q <= lease_ms_full;
    end
  end

  // Request decode: slot number from the last address byte.
  assign req_slot8 = item_q.requested_ip[7:0] - base_host_q;
  assign req_slot  = req_slot8[IdxW-1:0];
  assign req_owner = owner_q[req_slot];
  assign lease_end = item_q.now_ms + lease_ms_q;

  // Walk examination of the current slot.
  assign walk_owner   = owner_q[idx_q];
  assign walk_full    = {expiry_q[idx_q], ExpiryLowFill};
  assign walk_diff    = walk_full - item_q.now_ms;
  assign walk_expired = walk_diff[31];
  assign walk_match   = (walk_owner == item_q.client_mac);

  // Walk index and candidate slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      pick_q       <= '0;
      pick_valid_q <= 1'b0;
    end else if (cmd_i.walk_init) begin
      idx_q        <= '0;
      pick_valid_q <= 1'b0;
    end else if (cmd_i.walk_step) begin
      idx_q <= idx_q + 1'b1;
      if (walk_match) begin
        pick_q       <= idx_q;
        pick_valid_q <= 1'b1;
      end else if (!pick_valid_q && (walk_owner == '0 || walk_expired)) begin
        pick_q       <= idx_q;
        pick_valid_q <= 1'b1;
      end
    end
  end

  // Lease table updates: an expired slot is freed when the walk picks it, requests claim.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LeaseSlots; i++) begin
        owner_q[i]  <= '0;
        expiry_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      owner_q[req_slot]  <= item_q.client_mac;
      expiry_q[req_slot] <= lease_end[31:16];
    end else if (cmd_i.walk_step && !walk_match && !pick_valid_q && walk_expired) begin
      owner_q[idx_q] <= '0;
    end
  end

  // Address of the slot named in the reply.
  assign post_slot = (cmd_i.kind == KIND_OFFER) ? pick_q : req_slot;
  assign post_ip   = {server_ip_q[31:8], base_host_q + 8'(post_slot)};

  // Reply register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_kind_q  <= KIND_NONE;
      res_ip_q    <= '0;
      res_cause_q <= CAUSE_NONE;
    end else if (cmd_i.post) begin
      res_kind_q  <= cmd_i.kind;
      res_cause_q <= cmd_i.cause;
      res_ip_q    <= (cmd_i.kind == KIND_NONE) ? '0 : post_ip;
    end
  end

  assign rsp_o.reply_kind  = res_kind_q;
  assign rsp_o.assigned_ip = res_ip_q;
  assign rsp_o.drop_cause  = res_cause_q;

  // Status toward the controller.
  assign status_o.type_present = item_q.type_present;
  assign status_o.is_discover  = (item_q.mode == ModeDiscover);
  assign status_o.is_request   = (item_q.mode == ModeRequest);
  assign status_o.req_present  = item_q.requested_present;
  assign status_o.subnet_ok    = (item_q.requested_ip[31:8] == server_ip_q[31:8]);
  assign status_o.slot_ok      = (req_slot8 < 8'(LeaseSlots));
  assign status_o.held         = (req_owner != item_q.client_mac) && (req_owner != '0);
  assign status_o.walk_match   = walk_match;
  assign status_o.walk_last    = (idx_q == IdxW'(LeaseSlots - 1));
  assign status_o.pick_valid   = pick_valid_q;

`ifndef SYNTH
  // A candidate appears only as the result of a walk step.
  a_pick_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pick_valid_q) |-> $past(cmd_i.walk_step))
    else $error("candidate slot set without a walk step");

  // A claim leaves the slot owned by the requesting client.
  a_commit_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (owner_q[req_slot] == item_q.client_mac))
    else $error("claimed slot not owned by client");

  // A dropped reply never carries an address.
  a_drop_no_ip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_kind_q == KIND_NONE) |-> (res_ip_q == '0))
    else $error("dropped reply carries an address");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/dla_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// DHCP lease allocator controller
// State machine that sequences decode, slot walk, claim and reply.
// ----------------------------------------------------------------------------
module dla_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire dla_pkg::status_t  status_i,
  output dla_pkg::cmd_t          cmd_o
);
  import dla_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (status_i.type_present && status_i.is_discover) state_d = S_WALK;
        else state_d = S_RESULT;
      end
      S_WALK: begin
        if (status_i.walk_match || status_i.walk_last) state_d = S_WALK_END;
      end
      S_WALK_END: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd_o       = '0;
    cmd_o.kind  = KIND_NONE;
    cmd_o.cause = CAUSE_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_DECODE: begin
        if (!status_i.type_present) begin
          cmd_o.post  = 1'b1;
          cmd_o.cause = CAUSE_NO_TYPE;
        end else if (status_i.is_discover) begin
          cmd_o.walk_init = 1'b1;
        end else if (status_i.is_request) begin
          cmd_o.post = 1'b1;
          if (!status_i.req_present) begin
            cmd_o.cause = CAUSE_NO_REQ;
          end else if (!status_i.subnet_ok) begin
            cmd_o.cause = CAUSE_FOREIGN;
          end else if (!status_i.slot_ok) begin
            cmd_o.cause = CAUSE_RANGE;
          end else if (status_i.held) begin
            cmd_o.cause = CAUSE_HELD;
          end else begin
            cmd_o.commit = 1'b1;
            cmd_o.kind   = KIND_ACK;
          end
        end else begin
          cmd_o.post = 1'b1;
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
      end
      S_WALK_END: begin
        cmd_o.post = 1'b1;
        if (status_i.pick_valid) cmd_o.kind = KIND_OFFER;
        else cmd_o.cause = CAUSE_FULL;
      end
      S_RESULT: begin
        out_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // A claim happens only for an in-range slot that no other client holds.
  a_commit_checked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (status_i.slot_ok && !status_i.held && status_i.subnet_ok))
    else $error("claim without passing request checks");

  // Every item captured is followed by its decode cycle.
  a_load_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_DECODE))
    else $error("captured item not decoded");

  // The reply is written in the cycle before it is offered.
  a_post_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.post |=> out_valid_o)
    else $error("posted reply not presented");
`endif

endmodule
`default_nettype wire
